@@ hw/rtl/pdi_pkg.sv @@
// ----------------------------------------------------------------------------
// pdi_pkg
// shared types, constants and helpers of the particle drag integrator
// ----------------------------------------------------------------------------
package pdi_pkg;

  localparam int STEP_SCALE_DEF = 100;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_ACCEL_X   = 3'd0,
    CFG_ACCEL_Y   = 3'd1,
    CFG_ACCEL_Z   = 3'd2,
    CFG_DRAG      = 3'd3,
    CFG_FADE      = 3'd4,
    CFG_LAUNCH_VX = 3'd5,
    CFG_LAUNCH_VY = 3'd6,
    CFG_LAUNCH_VZ = 3'd7
  } cfg_idx_t;

  localparam logic [31:0] ACCEL_Y_RST  = 32'hFFFF_CCCD;
  localparam logic [23:0] DRAG_RST     = 24'd251658;
  localparam logic [23:0] FADE_RST     = 24'd52429;
  localparam logic [31:0] LAUNCH_Y_RST = 32'd655360;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOSS, ST_SQ, ST_SQACC, ST_ROOT, ST_K, ST_KW,
    ST_D, ST_A, ST_AH, ST_V, ST_PH, ST_P, ST_DONE
  } state_t;

  // clip a wide signed value to 32 bits, flag in the top bit
  function automatic logic [32:0] sat32(input logic signed [49:0] x);
    logic [32:0] r;
    if (x > 50'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -50'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

  // magnitude of a signed 32 bit word
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

endpackage

@@ hw/rtl/particle_drag_integrator.sv @@
// ----------------------------------------------------------------------------
// particle_drag_integrator
// one particle advanced per tick, semi-implicit euler with quadratic drag
// ----------------------------------------------------------------------------
// channel | signals                                         | direction
// input   | in_valid in_ready cmd time_step                 | in
// output  | out_valid out_ready pos_x/y/z opacity saturated | out
// config  | cfg_valid cfg_ready cfg_addr cfg_data           | in
//
// an advance tick runs a bit-serial square root and uses the single 32x32
// multiplier 14 times; a restart loads the launch velocities and skips both
// in_ready is high only in idle; a finished beat sits in the output register
// so the next tick is taken while the result waits
// reset (rst, synchronous) loads register defaults, zero position, full alpha
// config writes are always taken
module particle_drag_integrator #(
  parameter int STEP_SCALE = pdi_pkg::STEP_SCALE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] time_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic [16:0] opacity,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import pdi_pkg::*;

  localparam int HW = $clog2(65535 * STEP_SCALE + 1);

  state_t st, st_next;

  logic [31:0] accel [3];
  logic [31:0] launch [3];
  logic [23:0] drag, fade;

  logic signed [31:0] vel [3];
  logic signed [31:0] pos [3];
  logic [16:0] alpha;
  logic        sat;

  logic [15:0]   t_reg;
  logic [HW-1:0] h;
  logic [1:0]    ax;
  logic [4:0]    cnt;
  logic [63:0]   acc, rad;
  logic [34:0]   rem;
  logic [31:0]   root, kreg;
  logic signed [31:0] a_reg;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic out_load;

  assign in_ready  = (st == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_load  = (st == ST_DONE) && (!out_valid || out_ready);

  // state register
  always_ff @(posedge clk) begin
    if (rst) st <= ST_IDLE;
    else     st <= st_next;
  end

  // sequencer and multiplier operand select
  always_comb begin
    st_next = st;
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      ST_IDLE: begin
        if (in_valid) st_next = (cmd == CMD_RESTART) ? ST_DONE : ST_LOSS;
      end
      ST_LOSS: begin
        mul_a = {16'd0, t_reg};
        mul_b = {8'd0, fade};
        st_next = ST_SQ;
      end
      ST_SQ: begin
        mul_a = mag32(vel[ax]);
        mul_b = mag32(vel[ax]);
        if (ax == 2'd2) st_next = ST_SQACC;
      end
      ST_SQACC: st_next = ST_ROOT;
      ST_ROOT:  if (cnt == 5'd31) st_next = ST_K;
      ST_K: begin
        mul_a = root;
        mul_b = {8'd0, drag};
        st_next = ST_KW;
      end
      ST_KW: st_next = ST_D;
      ST_D: begin
        mul_a = kreg;
        mul_b = mag32(vel[ax]);
        st_next = ST_A;
      end
      ST_A: st_next = ST_AH;
      ST_AH: begin
        mul_a = mag32(a_reg);
        mul_b = 32'(h);
        st_next = ST_V;
      end
      ST_V: st_next = ST_PH;
      ST_PH: begin
        mul_a = mag32(vel[ax]);
        mul_b = 32'(h);
        st_next = ST_P;
      end
      ST_P:    st_next = (ax == 2'd2) ? ST_DONE : ST_D;
      ST_DONE: if (out_load) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  // shared multiplier, product registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accel[0]  <= '0;
      accel[1]  <= ACCEL_Y_RST;
      accel[2]  <= '0;
      drag      <= DRAG_RST;
      fade      <= FADE_RST;
      launch[0] <= '0;
      launch[1] <= LAUNCH_Y_RST;
      launch[2] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ACCEL_X:   accel[0]  <= cfg_data;
        CFG_ACCEL_Y:   accel[1]  <= cfg_data;
        CFG_ACCEL_Z:   accel[2]  <= cfg_data;
        CFG_DRAG:      drag      <= cfg_data[23:0];
        CFG_FADE:      fade      <= cfg_data[23:0];
        CFG_LAUNCH_VX: launch[0] <= cfg_data;
        CFG_LAUNCH_VY: launch[1] <= cfg_data;
        CFG_LAUNCH_VZ: launch[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath
  logic [31:0]        sq_trial;
  logic [34:0]        rem_sh, rem_test;
  logic [47:0]        dmag;
  logic signed [49:0] a_wide, v_wide, p_wide, step;
  logic [32:0]        a_sat, v_sat, p_sat;

  always_comb begin
    sq_trial = '0;
    rem_sh   = {rem[32:0], rad[63:62]};
    rem_test = {1'b0, root, 2'b01};
    dmag     = prod[63:16];
    a_wide   = 50'(signed'(accel[ax])) -
               (vel[ax][31] ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag}));
    a_sat    = sat32(a_wide);
    step     = $signed({2'b00, dmag});
    v_wide   = 50'(vel[ax]) + (a_reg[31] ? -step : step);
    v_sat    = sat32(v_wide);
    p_wide   = 50'(pos[ax]) + (vel[ax][31] ? -step : step);
    p_sat    = sat32(p_wide);
    sq_trial = root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel[0] <= '0;
      vel[1] <= LAUNCH_Y_RST;
      vel[2] <= '0;
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
      alpha  <= ALPHA_ONE;
      sat    <= 1'b0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (in_valid) begin
            t_reg <= time_step;
            h     <= HW'(time_step * STEP_SCALE);
            sat   <= 1'b0;
            ax    <= '0;
            acc   <= '0;
            if (cmd == CMD_RESTART) begin
              for (int i = 0; i < 3; i++) begin
                vel[i] <= launch[i];
                pos[i] <= '0;
              end
            end
          end
        end
        ST_SQ: begin
          // first pass takes the alpha loss, later ones sum squares
          if (ax == 2'd0) begin
            if (prod[39:16] >= {7'd0, alpha}) alpha <= '0;
            else alpha <= alpha - prod[32:16];
          end else begin
            acc <= acc + prod;
          end
          ax <= ax + 2'd1;
        end
        ST_SQACC: begin
          rad  <= acc + prod;
          rem  <= '0;
          root <= '0;
          cnt  <= '0;
        end
        // restoring square root, one result bit a cycle
        ST_ROOT: begin
          rad <= {rad[61:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (rem_sh >= rem_test) begin
            rem  <= rem_sh - rem_test;
            root <= {sq_trial[30:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {sq_trial[30:0], 1'b0};
          end
        end
        ST_KW: begin
          kreg <= prod[55:24];
          ax   <= '0;
        end
        ST_A: a_reg <= a_sat[31:0];
        ST_V: begin
          vel[ax] <= v_sat[31:0];
          sat     <= sat | v_sat[32];
        end
        ST_P: begin
          pos[ax] <= p_sat[31:0];
          sat     <= sat | p_sat[32];
          ax      <= ax + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      pos_x     <= pos[0];
      pos_y     <= pos[1];
      pos_z     <= pos[2];
      opacity   <= alpha;
      saturated <= sat;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/pdi_checker.sv @@
// ----------------------------------------------------------------------------
// pdi_checker
// port level checks of the particle drag integrator
// ----------------------------------------------------------------------------
module pdi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] opacity
);
  import pdi_pkg::*;

  logic [16:0] last_op;

  // last delivered alpha
  always_ff @(posedge clk) begin
    if (rst) last_op <= ALPHA_ONE;
    else if (out_valid && out_ready) last_op <= opacity;
  end

  // a held result beat stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // block is busy right after taking a tick
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // alpha never rises between results
  a_fade: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> opacity <= last_op)
    else $error("alpha increased");

  // alpha stays within full opacity
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> opacity <= ALPHA_ONE)
    else $error("alpha above one");

endmodule

bind particle_drag_integrator pdi_checker u_pdi_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .opacity(opacity)
);

@@ tb/sv/tb_particle_drag_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_drag_integrator
// self-checking bench: ticks and restarts are driven with random bursts and
// output stalls, each beat is checked against a built-in fixed point model
// of the drag integrator under several register settings
// ----------------------------------------------------------------------------
module tb_particle_drag_integrator;
  import pdi_pkg::*;

  localparam int STEP = STEP_SCALE_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [16:0] alpha;
    logic        clip;
  } particle_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = CMD_ADVANCE;
  logic [15:0] time_step = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pos_x, pos_y, pos_z;
  logic [16:0] opacity;
  logic        saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_addr = CFG_ACCEL_X;
  logic [31:0] cfg_data = '0;

  particle_drag_integrator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [31:0]    regs [8];
  longint         pos_m [3];
  longint         vel_m [3];
  longint         alpha_m;
  particle_beat_t pending_beats [$];
  int             errors = 0;

  // sender and receiver controls
  int gap_max = 3;
  int burst_left = 0;
  int hold_left = 0;
  int stall_pct = 20;
  int stall_phase = 0;
  int idle_cycles = 0;

  function automatic longint clip32(input longint x, inout bit flag);
    if (x > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint unsigned magn(input longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  // (|x|*h)>>16 with the sign of x restored
  function automatic longint scale_by_step(input longint x, input longint unsigned h);
    longint unsigned p;
    p = (magn(x) * h) >> 16;
    return x < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic model_reset();
    regs[CFG_ACCEL_X] = '0;
    regs[CFG_ACCEL_Y] = ACCEL_Y_RST;
    regs[CFG_ACCEL_Z] = '0;
    regs[CFG_DRAG] = {8'd0, DRAG_RST};
    regs[CFG_FADE] = {8'd0, FADE_RST};
    regs[CFG_LAUNCH_VX] = '0;
    regs[CFG_LAUNCH_VY] = LAUNCH_Y_RST;
    regs[CFG_LAUNCH_VZ] = '0;
    for (int i = 0; i < 3; i++) begin
      pos_m[i] = 0;
      vel_m[i] = longint'($signed(regs[CFG_LAUNCH_VX + i]));
    end
    alpha_m = ALPHA_ONE;
  endtask

  // advance or restart the particle and return the beat it produces
  function automatic particle_beat_t integrate_tick(input logic c, input logic [15:0] t);
    particle_beat_t r;
    bit clip, dummy;
    longint unsigned loss, h, sumsq, speed, k, d;
    longint drag, acc;
    clip = 1'b0;
    dummy = 1'b0;
    if (c == CMD_RESTART) begin
      for (int i = 0; i < 3; i++) begin
        pos_m[i] = 0;
        vel_m[i] = longint'($signed(regs[CFG_LAUNCH_VX + i]));
      end
    end else begin
      loss = (longint'(t) * longint'(regs[CFG_FADE][23:0])) >> 16;
      h = longint'(t) * STEP;
      alpha_m = (loss >= alpha_m) ? 0 : alpha_m - longint'(loss);
      sumsq = 0;
      for (int i = 0; i < 3; i++) sumsq += magn(vel_m[i]) * magn(vel_m[i]);
      speed = floor_sqrt(sumsq);
      k = (longint'(regs[CFG_DRAG][23:0]) * speed) >> 24;
      for (int i = 0; i < 3; i++) begin
        d = (k * magn(vel_m[i])) >> 16;
        drag = vel_m[i] < 0 ? -longint'(d) : longint'(d);
        acc = clip32(longint'($signed(regs[CFG_ACCEL_X + i])) - drag, dummy);
        vel_m[i] = clip32(vel_m[i] + scale_by_step(acc, h), clip);
        pos_m[i] = clip32(pos_m[i] + scale_by_step(vel_m[i], h), clip);
      end
    end
    r.px = pos_m[0][31:0];
    r.py = pos_m[1][31:0];
    r.pz = pos_m[2][31:0];
    r.alpha = alpha_m[16:0];
    r.clip = clip;
    return r;
  endfunction

  // send one tick beat, bursts with random gaps between them
  task automatic send_tick(input logic c, input logic [15:0] t);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    time_step <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_beats.push_back(integrate_tick(c, t));
  endtask

  task automatic release_input();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    regs[idx] = (idx == CFG_DRAG || idx == CFG_FADE) ? {8'd0, val[23:0]} : val;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic load_registers(input logic [31:0] ax, ay, az, dr, fd, lx, ly, lz);
    wait_drained();
    write_reg(CFG_ACCEL_X, ax);
    write_reg(CFG_ACCEL_Y, ay);
    write_reg(CFG_ACCEL_Z, az);
    write_reg(CFG_DRAG, dr);
    write_reg(CFG_FADE, fd);
    write_reg(CFG_LAUNCH_VX, lx);
    write_reg(CFG_LAUNCH_VY, ly);
    write_reg(CFG_LAUNCH_VZ, lz);
  endtask

  // mostly moderate values, now and then a full-range word
  function automatic logic [31:0] pick_word(input int bits);
    if ($urandom_range(9) == 0) return $urandom();
    return 32'($signed($urandom_range((1 << bits) - 1)) - (1 << (bits - 1)));
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(9))
      0: return 16'($urandom_range(16'hFFFF));
      1: return '0;
      default: return 16'($urandom_range(1500));
    endcase
  endfunction

  // defaults after reset: zero step, tiny and full steps, restart
  task automatic test_reset_defaults();
    send_tick(CMD_ADVANCE, 16'd0);
    send_tick(CMD_ADVANCE, 16'd1);
    send_tick(CMD_ADVANCE, 16'd1092);
    send_tick(CMD_ADVANCE, 16'd1092);
    send_tick(CMD_RESTART, 16'hFFFF);
    send_tick(CMD_ADVANCE, 16'hFFFF);
    send_tick(CMD_RESTART, 16'd0);
  endtask

  // register extremes: saturation, full drag, alpha floor, zero drag
  task automatic test_extremes();
    load_registers(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFF_FFFF,
                   32'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(CMD_RESTART, 16'd5);
    send_tick(CMD_ADVANCE, 16'hFFFF);
    send_tick(CMD_ADVANCE, 16'hFFFF);
    send_tick(CMD_ADVANCE, 16'd0);
    send_tick(CMD_ADVANCE, 16'h8000);
    load_registers(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                   32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(CMD_RESTART, 16'd0);
    send_tick(CMD_ADVANCE, 16'hFFFF);
    send_tick(CMD_ADVANCE, 16'd1);
    load_registers(32'd0, 32'd0, 32'd0, 32'hFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd0);
    send_tick(CMD_RESTART, 16'd0);
    send_tick(CMD_ADVANCE, 16'hFFFF);
    send_tick(CMD_ADVANCE, 16'd7);
  endtask

  // long output hold-off while ticks keep coming, then a full pause
  task automatic test_backpressure();
    hold_left = 300;
    gap_max = 0;
    for (int n = 0; n < 10; n++) send_tick($urandom_range(7) == 0, pick_step());
    wait_drained();
    gap_max = 3;
  endtask

  // random ticks under a series of random register settings
  task automatic test_random_ticks();
    for (int phase = 0; phase < 5; phase++) begin
      load_registers(pick_word(20), pick_word(20), pick_word(20),
                     $urandom_range(24'hFF_FFFF) >> $urandom_range(12),
                     $urandom_range(24'hFF_FFFF) >> $urandom_range(20),
                     pick_word(24), pick_word(24), pick_word(24));
      gap_max = (phase == 2) ? 0 : 4;
      send_tick(CMD_RESTART, 16'($urandom_range(16'hFFFF)));
      for (int n = 0; n < 275; n++)
        send_tick($urandom_range(19) == 0, pick_step());
    end
  endtask

  // receiver stall rate changes on its own schedule
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      stall_phase++;
      if (stall_phase % 97 == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 15;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // compare each output beat with the oldest pending prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        particle_beat_t e;
        e = pending_beats.pop_front();
        if (pos_x !== e.px) begin
          $error("pos_x exp %h act %h", e.px, pos_x);
          errors++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y exp %h act %h", e.py, pos_y);
          errors++;
        end
        if (pos_z !== e.pz) begin
          $error("pos_z exp %h act %h", e.pz, pos_z);
          errors++;
        end
        if (opacity !== e.alpha) begin
          $error("opacity exp %0d act %0d", e.alpha, opacity);
          errors++;
        end
        if (saturated !== e.clip) begin
          $error("saturated exp %0d act %0d", e.clip, saturated);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_reset_defaults();
    test_extremes();
    test_backpressure();
    test_random_ticks();
    wait_drained();
    if (errors == 0 && pending_beats.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ particle_drag_integrator.f @@
hw/rtl/pdi_pkg.sv
hw/rtl/particle_drag_integrator.sv
hw/rtl/pdi_checker.sv
tb/sv/tb_particle_drag_integrator.sv
